### rtl/core/anbs_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// anbs_pkg: shared types and constants of the annex b splitter
// result beat layout, the per-byte result burst and stream byte codes
// ----------------------------------------------------------------------------
package anbs_pkg;

   localparam int unsigned ByteW             = 8;
   localparam int unsigned TypeW             = 5;
   // most result beats one stream byte can release
   localparam int unsigned MaxBurst          = 5;
   localparam int unsigned BurstCntW         = 3;
   localparam int unsigned QueueDepthDefault = 8;
   localparam int unsigned ResultUserW       = TypeW + 2;

   localparam logic [ByteW-1:0] ByteZero = 8'h00;
   localparam logic [ByteW-1:0] ByteOne  = 8'h01;
   localparam logic [ByteW-1:0] TypeMask = 8'h1f;

   // zero run length a start code needs, and the one at which it becomes long
   localparam logic [1:0] RunShort = 2'd2;
   localparam logic [1:0] RunLong  = 2'd3;

   typedef struct packed {
      logic [ByteW-1:0] payload_byte;
      logic             first_of_unit;
      logic             last_of_unit;
      logic [TypeW-1:0] unit_type;
      logic             long_start_code;
   } result_type;

   typedef struct packed {
      logic [BurstCntW-1:0]        count;
      result_type [MaxBurst-1:0]   item;
   } burst_type;

endpackage
`default_nettype wire

### rtl/core/anbs_parse.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// anbs_parse: input register and start code scanner
// registers each stream byte, tracks zero runs and the held-back payload byte,
// and hands the result beats of one byte to the queue as a burst
// ----------------------------------------------------------------------------
module anbs_parse (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      req_tvalid,
   output logic                           req_tready,
   input  wire logic [anbs_pkg::ByteW-1:0] req_tdata,
   input  wire logic                      req_tlast,
   input  wire logic                      room,
   output anbs_pkg::burst_type            burst
);
   import anbs_pkg::*;

   logic             in_valid_ff, in_valid_in;
   logic [ByteW-1:0] in_byte_ff;
   logic             in_eos_ff;

   logic             inside_ff, inside_in;
   logic [1:0]       zero_run_ff, zero_run_in;
   logic             held_valid_ff, held_valid_in;
   logic [ByteW-1:0] held_byte_ff, held_byte_in;
   logic             held_first_ff, held_first_in;
   logic [TypeW-1:0] type_ff, type_in;
   logic             long_ff, long_in;
   logic             awaiting_ff, awaiting_in;

   logic fire;

   assign fire       = in_valid_ff & room;
   assign req_tready = ~in_valid_ff | room;
   assign in_valid_in = req_tready ? req_tvalid : in_valid_ff;

   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         in_byte_ff <= req_tdata;
         in_eos_ff  <= req_tlast;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff   <= 1'b0;
         inside_ff     <= 1'b0;
         zero_run_ff   <= '0;
         held_valid_ff <= 1'b0;
         held_byte_ff  <= '0;
         held_first_ff <= 1'b0;
         type_ff       <= '0;
         long_ff       <= 1'b0;
         awaiting_ff   <= 1'b0;
      end else begin
         in_valid_ff   <= in_valid_in;
         inside_ff     <= inside_in;
         zero_run_ff   <= zero_run_in;
         held_valid_ff <= held_valid_in;
         held_byte_ff  <= held_byte_in;
         held_first_ff <= held_first_in;
         type_ff       <= type_in;
         long_ff       <= long_in;
         awaiting_ff   <= awaiting_in;
      end
   end

   // the beats of one byte are: the held byte, then pushed zeros, then the
   // new byte; all but the newest go out unless the unit closes here
   always_comb begin
      logic                 is_zero;
      logic                 is_start;
      logic                 push_byte;
      logic [1:0]           run_mid;
      logic [BurstCntW-1:0] n_main;
      logic [BurstCntW-1:0] n_eos;
      logic [BurstCntW-1:0] n_zero;
      logic [BurstCntW-1:0] pushes;
      logic [BurstCntW-1:0] seq_len;
      logic [BurstCntW-1:0] emit_cnt;
      logic [BurstCntW-1:0] pos;
      logic [BurstCntW-1:0] rel;
      logic                 closing;
      logic                 push_any;
      logic [TypeW-1:0]     hdr_type;
      logic [TypeW-1:0]     emit_type;

      is_zero   = (in_byte_ff == ByteZero);
      is_start  = (in_byte_ff == ByteOne) && (zero_run_ff >= RunShort);
      push_byte = 1'b0;
      n_main    = '0;
      run_mid   = '0;
      if (is_zero) begin
         run_mid = (zero_run_ff == RunLong) ? RunLong : zero_run_ff + 2'd1;
         n_main  = {{(BurstCntW-1){1'b0}}, (zero_run_ff == RunLong) && inside_ff};
      end else if (!is_start) begin
         push_byte = inside_ff;
         n_main    = inside_ff ? {1'b0, zero_run_ff} : '0;
      end
      n_eos    = (in_eos_ff && inside_ff) ? {1'b0, run_mid} : '0;
      n_zero   = n_main + n_eos;
      pushes   = n_zero + {{(BurstCntW-1){1'b0}}, push_byte};
      seq_len  = pushes + {{(BurstCntW-1){1'b0}}, held_valid_ff};
      closing  = is_start || (in_eos_ff && inside_ff);
      push_any = (pushes != '0);
      if (closing) begin
         emit_cnt = seq_len;
      end else if (seq_len != '0) begin
         emit_cnt = seq_len - 3'd1;
      end else begin
         emit_cnt = '0;
      end

      // a header pushed here is a zero if any zero goes ahead of the byte
      hdr_type  = (n_zero != '0) ? '0 : in_byte_ff[TypeW-1:0];
      emit_type = (awaiting_ff && push_any) ? hdr_type : type_ff;

      burst.count = fire ? emit_cnt : '0;
      for (int i = 0; i < MaxBurst; i++) begin
         pos = BurstCntW'(i);
         rel = pos - {{(BurstCntW-1){1'b0}}, held_valid_ff};
         burst.item[i].unit_type       = emit_type;
         burst.item[i].long_start_code = long_ff;
         burst.item[i].last_of_unit    = closing && (pos == seq_len - 3'd1);
         if (held_valid_ff && (pos == '0)) begin
            burst.item[i].payload_byte  = held_byte_ff;
            burst.item[i].first_of_unit = held_first_ff;
         end else begin
            burst.item[i].payload_byte  = (rel < n_zero) ? ByteZero : in_byte_ff;
            burst.item[i].first_of_unit = awaiting_ff && (rel == '0);
         end
      end

      inside_in     = inside_ff;
      zero_run_in   = zero_run_ff;
      held_valid_in = held_valid_ff;
      held_byte_in  = held_byte_ff;
      held_first_in = held_first_ff;
      type_in       = type_ff;
      long_in       = long_ff;
      awaiting_in   = awaiting_ff;
      if (fire) begin
         if (in_eos_ff) begin
            // end of stream: everything back to the reset picture
            inside_in     = 1'b0;
            zero_run_in   = '0;
            held_valid_in = 1'b0;
            held_byte_in  = '0;
            held_first_in = 1'b0;
            type_in       = '0;
            long_in       = 1'b0;
            awaiting_in   = 1'b0;
         end else begin
            zero_run_in = run_mid;
            if (is_start) begin
               inside_in     = 1'b1;
               awaiting_in   = 1'b1;
               long_in       = (zero_run_ff == RunLong);
               held_valid_in = 1'b0;
            end else if (push_any) begin
               held_valid_in = 1'b1;
               held_byte_in  = push_byte ? in_byte_ff : ByteZero;
               held_first_in = awaiting_ff && (pushes == 3'd1);
               awaiting_in   = 1'b0;
               if (awaiting_ff) begin
                  type_in = hdr_type;
               end
            end
         end
      end
   end

   a_held_inside : assert property (@(posedge clock) disable iff (reset)
      held_valid_ff |-> inside_ff)
      else $error("held byte outside a unit");

   a_header_unheld : assert property (@(posedge clock) disable iff (reset)
      awaiting_ff |-> !held_valid_ff)
      else $error("byte held while the header is still awaited");

   a_burst_size : assert property (@(posedge clock) disable iff (reset)
      (burst.count != '0) |-> (fire && (burst.count <= BurstCntW'(MaxBurst))))
      else $error("burst without an accepted byte or too long");

endmodule
`default_nettype wire

### rtl/core/anbs_result_queue.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// anbs_result_queue: result beat queue
// takes a burst of up to five beats per cycle and drives them out one a beat
// ----------------------------------------------------------------------------
module anbs_result_queue #(
   parameter int unsigned Depth = anbs_pkg::QueueDepthDefault
) (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire anbs_pkg::burst_type              burst,
   output logic                                  room,
   output logic                                  rsp_tvalid,
   input  wire logic                             rsp_tready,
   output logic [anbs_pkg::ByteW-1:0]            rsp_tdata,
   output logic                                  rsp_tlast,
   output logic [anbs_pkg::ResultUserW-1:0]      rsp_tuser
);
   import anbs_pkg::*;

   localparam int unsigned PtrW = $clog2(Depth);
   localparam int unsigned CntW = $clog2(Depth + 1);

   result_type       mem_ff [Depth];
   logic [PtrW-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [PtrW-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [CntW-1:0]  count_ff, count_in;
   logic             pop;
   result_type       head;

   // pointer plus a small step, wrapped at the depth
   function automatic logic [PtrW-1:0] wrap_add(input logic [PtrW-1:0] base,
                                                input logic [BurstCntW-1:0] step);
      logic [PtrW:0] sum;
      sum = {1'b0, base} + (PtrW+1)'(step);
      if (sum >= (PtrW+1)'(Depth)) begin
         sum = sum - (PtrW+1)'(Depth);
      end
      return sum[PtrW-1:0];
   endfunction

   assign room       = (count_ff <= CntW'(Depth - MaxBurst));
   assign rsp_tvalid = (count_ff != '0);
   assign pop        = rsp_tvalid & rsp_tready;
   assign head       = mem_ff[rd_ptr_ff];
   assign rsp_tdata  = head.payload_byte;
   assign rsp_tlast  = head.last_of_unit;
   assign rsp_tuser  = {head.long_start_code, head.unit_type, head.first_of_unit};

   assign wr_ptr_in = wrap_add(wr_ptr_ff, burst.count);
   assign rd_ptr_in = wrap_add(rd_ptr_ff, {{(BurstCntW-1){1'b0}}, pop});
   assign count_in  = count_ff + CntW'(burst.count) - CntW'(pop);

   always_ff @(posedge clock) begin
      for (int k = 0; k < MaxBurst; k++) begin
         if (BurstCntW'(k) < burst.count) begin
            mem_ff[wrap_add(wr_ptr_ff, BurstCntW'(k))] <= burst.item[k];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   a_count_bound : assert property (@(posedge clock) disable iff (reset)
      count_ff <= CntW'(Depth))
      else $error("queue fill beyond depth");

   a_write_room : assert property (@(posedge clock) disable iff (reset)
      (burst.count != '0) |-> room)
      else $error("burst written without room");

   a_count_track : assert property (@(posedge clock) disable iff (reset)
      !$past(reset) |-> (count_ff == $past(count_ff) + CntW'($past(burst.count))
                                     - CntW'($past(pop))))
      else $error("queue fill out of step with writes and reads");

endmodule
`default_nettype wire

### rtl/core/annexb_nal_unit_splitter.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// annexb_nal_unit_splitter: h.264 annex b start code splitter
// cuts an annex b byte stream into nal unit payload beats
// ----------------------------------------------------------------------------
// usage
//   req_ carries the byte stream, one byte per beat in req_tdata; req_tlast
//   marks the final byte of the stream and closes the open unit
//   rsp_ carries payload beats with start codes removed; rsp_tlast marks the
//   last byte of a unit, rsp_tuser holds the header flag, unit type and
//   long start code flag
//   every byte position is tested for 00 00 01 and 00 00 00 01
// timing
//   one byte per cycle sustained while the queue has room; a byte is
//   registered in the input register, its beats are written into the result
//   queue when it has room and are then taken from the queue head
//   the zero run, up to three zeros, and one further beat are held back until
//   the unit end is known, so beats may trail their byte by several stream bytes
//   a byte releases at most five beats; the input register advances when the
//   queue has room for a whole burst; an empty input register is always ready
// reset and stall
//   synchronous reset empties the queue and drops back to hunting for a
//   start code; a stalled receiver holds the head beat, and once the queue
//   fills the input side stops taking bytes; nothing is lost
// ----------------------------------------------------------------------------
module annexb_nal_unit_splitter #(
   parameter int unsigned QUEUE_DEPTH = anbs_pkg::QueueDepthDefault
) (
   input  wire logic                        clock,
   input  wire logic                        reset,
   // stream byte side
   input  wire logic                        req_tvalid,
   output logic                             req_tready,
   input  wire logic [anbs_pkg::ByteW-1:0]  req_tdata,   // [7:0] data_byte
   input  wire logic                        req_tlast,   // end_of_stream
   // payload beat side
   output logic                             rsp_tvalid,
   input  wire logic                        rsp_tready,
   output logic [anbs_pkg::ByteW-1:0]       rsp_tdata,   // [7:0] payload_byte
   output logic                             rsp_tlast,   // last_of_unit
   // [0] first_of_unit, [5:1] unit_type, [6] long_start_code
   output logic [anbs_pkg::ResultUserW-1:0] rsp_tuser
);
   import anbs_pkg::*;

   // beats released by the byte in the input register
   burst_type burst;
   // queue can absorb a full burst
   logic      room;

   anbs_parse u_parse (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .room       (room),
      .burst      (burst)
   );

   anbs_result_queue #(
      .Depth (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .burst      (burst),
      .room       (room),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .rsp_tuser  (rsp_tuser)
   );

endmodule
`default_nettype wire
